@@ design/cse_pkg.sv @@
package cse_pkg;

    // Fixed field widths
    localparam int DATA_W      = 32;
    localparam int TERM_W      = 7;
    localparam int IDX_W       = 6;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;
    localparam int PADDR_W     = 4;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_LOW   = 2'd0;
    localparam logic [1:0] REG_HIGH  = 2'd1;
    localparam logic [1:0] REG_TERMS = 2'd2;

    // Request kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load_coeff;   // write one coefficient
        logic start_eval;   // capture flags, launch divider
        logic take_t;       // clip quotient into t, set up recurrence
        logic mul;          // read c[k], register t*y1
        logic upd;          // recurrence step
        logic fin;          // final combine with c[0]
        logic out_load;     // move result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic zero_width;   // a == b
        logic div_busy;     // divider still iterating
        logic one_term;     // only c[0] in use
        logic k_one;        // current step is term 1
    } t_status;

endpackage

@@ design/cse_div.sv @@
module cse_div #(
    parameter int DW = 49
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DW-1:0]                 i_dividend,
    input  logic [cse_pkg::DATA_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [DW-1:0]                 o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic                          r_busy;
    logic [CW-1:0]                 r_cnt;
    logic [DW-1:0]                 r_dq;    // dividend shifts out, quotient shifts in
    logic [cse_pkg::DATA_W-1:0]    r_rem;
    logic [cse_pkg::DATA_W-1:0]    r_dvs;

    logic [cse_pkg::DATA_W:0]      rem_sh;
    logic                          q_bit;
    logic [cse_pkg::DATA_W:0]      rem_diff;

    // One restoring step per cycle
    assign rem_sh   = {r_rem, r_dq[DW-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_dvs});
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DW-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[cse_pkg::DATA_W-1:0] : rem_sh[cse_pkg::DATA_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dq;

endmodule

@@ design/cse_datapath.sv @@
module cse_datapath #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cse_pkg::t_cmd                       i_cmd,
    output cse_pkg::t_status                    o_status,
    input  logic [cse_pkg::IDX_W-1:0]           i_coeff_index,
    input  logic signed [cse_pkg::DATA_W-1:0]   i_coeff_value,
    input  logic signed [cse_pkg::DATA_W-1:0]   i_x_value,
    input  logic signed [cse_pkg::DATA_W-1:0]   i_low,
    input  logic signed [cse_pkg::DATA_W-1:0]   i_high,
    input  logic [cse_pkg::TERM_W-1:0]          i_term_count,
    output logic [cse_pkg::DATA_W-1:0]          o_series_value,
    output logic                                o_outside,
    output logic                                o_zero_width,
    output logic                                o_saturated
);

    localparam int AW   = $clog2(MAX_TERMS);
    localparam int TCW  = (AW + 1 > cse_pkg::TERM_W) ? AW + 1 : cse_pkg::TERM_W;
    localparam int IXW  = (AW + 1 > cse_pkg::IDX_W) ? AW + 1 : cse_pkg::IDX_W;
    localparam int DW   = 33 + FRAC_BITS;

    localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MIN32 = 64'shFFFF_FFFF_8000_0000;
    localparam logic [DW-1:0]      POS_LIM = DW'(64'h0000_0000_7FFF_FFFF);
    localparam logic [DW-1:0]      NEG_LIM = DW'(64'h0000_0000_8000_0000);

    // Coefficient store
    logic signed [cse_pkg::DATA_W-1:0] r_mem [MAX_TERMS];
    logic signed [cse_pkg::DATA_W-1:0] r_mem_q;

    logic signed [cse_pkg::DATA_W-1:0] r_t;
    logic signed [cse_pkg::DATA_W-1:0] r_y1;
    logic signed [cse_pkg::DATA_W-1:0] r_y2;
    logic signed [63:0]                r_prod;
    logic [AW-1:0]                     r_k;
    logic                              r_neg;
    logic                              r_sat;
    logic                              r_zw;
    logic                              r_outside;
    logic signed [cse_pkg::DATA_W-1:0] r_fin;

    logic [cse_pkg::DATA_W-1:0]        r_out_value;
    logic                              r_out_outside;
    logic                              r_out_zw;
    logic                              r_out_sat;

    logic [IXW-1:0]                    idx_ext;
    logic                              idx_ok;
    logic [TCW-1:0]                    tc_ext;
    logic [AW-1:0]                     nm1;
    logic                              zw;
    logic                              outside;
    logic signed [33:0]                num;
    logic signed [32:0]                den;
    logic [33:0]                       mn;
    logic [32:0]                       md;
    logic                              div_start;
    logic                              div_busy;
    logic [DW-1:0]                     quot;
    logic signed [cse_pkg::DATA_W-1:0] t_clip;
    logic signed [63:0]                prod_c;
    logic signed [63:0]                prod_sh;
    logic signed [63:0]                sum;
    logic signed [cse_pkg::DATA_W-1:0] sum_clip;
    logic                              sum_ovf;

    // Load address check and term count limit
    assign idx_ext = IXW'(i_coeff_index);
    assign idx_ok  = (idx_ext < IXW'(MAX_TERMS));
    assign tc_ext  = TCW'(i_term_count);

    always_comb begin
        if (tc_ext == '0) begin
            nm1 = '0;
        end else if (tc_ext > TCW'(MAX_TERMS)) begin
            nm1 = AW'(MAX_TERMS - 1);
        end else begin
            nm1 = AW'(tc_ext - TCW'(1));
        end
    end

    // Interval flags
    assign zw      = (i_low == i_high);
    assign outside = ((i_x_value < i_low) && (i_x_value < i_high)) ||
                     ((i_x_value > i_low) && (i_x_value > i_high));

    // Map numerator and denominator to magnitudes
    assign num = {i_x_value[cse_pkg::DATA_W-1], i_x_value, 1'b0}
                 - 34'(i_low) - 34'(i_high);
    assign den = 33'(i_high) - 33'(i_low);
    assign mn  = num[33] ? 34'(-num) : 34'(num);
    assign md  = den[32] ? 33'(-den) : 33'(den);

    assign div_start = i_cmd.start_eval && !zw;

    cse_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({mn[32:0], {FRAC_BITS{1'b0}}}),
        .i_divisor  (md[31:0]),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    // Quotient clipped to 32 bits with sign applied
    always_comb begin
        if (r_neg) begin
            t_clip = (quot > NEG_LIM) ? MIN32[31:0] : 32'(-quot[31:0]);
        end else begin
            t_clip = (quot > POS_LIM) ? MAX32[31:0] : quot[31:0];
        end
    end

    // Shared multiply-add with clip
    assign prod_c  = r_t * r_y1;
    assign prod_sh = i_cmd.fin ? (r_prod >>> FRAC_BITS) : (r_prod >>> (FRAC_BITS - 1));
    assign sum     = prod_sh - 64'(r_y2) + 64'(r_mem_q);

    always_comb begin
        sum_ovf = 1'b1;
        if (sum > MAX32) begin
            sum_clip = MAX32[31:0];
        end else if (sum < MIN32) begin
            sum_clip = MIN32[31:0];
        end else begin
            sum_clip = sum[31:0];
            sum_ovf  = 1'b0;
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_coeff && idx_ok) begin
            r_mem[AW'(idx_ext)] <= i_coeff_value;
        end
        if (i_cmd.mul) begin
            r_mem_q <= r_mem[r_k];
        end
    end

    // Recurrence registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_eval) begin
            r_neg     <= num[33] ^ den[32];
            r_zw      <= zw;
            r_outside <= outside;
            r_sat     <= 1'b0;
            r_fin     <= '0;
        end
        if (i_cmd.take_t) begin
            r_t  <= t_clip;
            r_y1 <= '0;
            r_y2 <= '0;
            r_k  <= nm1;
        end
        if (i_cmd.mul) begin
            r_prod <= prod_c;
        end
        if (i_cmd.upd) begin
            r_y2  <= r_y1;
            r_y1  <= sum_clip;
            r_k   <= r_k - AW'(1);
            r_sat <= r_sat | sum_ovf;
        end
        if (i_cmd.fin) begin
            r_fin <= sum_clip;
            r_sat <= r_sat | sum_ovf;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value   <= r_fin;
            r_out_outside <= r_outside;
            r_out_zw      <= r_zw;
            r_out_sat     <= r_sat;
        end
    end

    assign o_status.zero_width = zw;
    assign o_status.div_busy   = div_busy;
    assign o_status.one_term   = (nm1 == '0);
    assign o_status.k_one      = (r_k == AW'(1));

    assign o_series_value = r_out_value;
    assign o_outside      = r_out_outside;
    assign o_zero_width   = r_out_zw;
    assign o_saturated    = r_out_sat;

endmodule

@@ design/cse_ctrl.sv @@
module cse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_req_type,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  cse_pkg::t_status    i_status,
    output cse_pkg::t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_TAKE = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_UPD  = 8'b0001_0000,
        S_FRD  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_req_type == cse_pkg::REQ_LOAD) begin
                        o_cmd.load_coeff = 1'b1;
                    end else begin
                        o_cmd.start_eval = 1'b1;
                        n_state = i_status.zero_width ? S_DONE : S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd.take_t = 1'b1;
                n_state = i_status.one_term ? S_FRD : S_RD;
            end
            S_RD: begin
                o_cmd.mul = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = i_status.k_one ? S_FRD : S_RD;
            end
            S_FRD: begin
                o_cmd.mul = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output beat pending
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/chebyshev_series_eval.sv @@
// Chebyshev series evaluator on [a,b] by Clenshaw's recurrence, signed Q16.16.
// Input stream s_axis: tuser selects the request (0 loads coefficient
// coeff_index with coeff_value, 1 evaluates the series at x_value). A load
// beat gives no output; an evaluate beat gives exactly one m_axis beat with
// the value and the outside, zero-width and saturation flags.
// Interval ends and the number of terms N are set over the APB port; the
// user must write them only while the block is idle, which the block does
// not enforce. Registers at 0x0 (a), 0x4 (b), 0x8 (N). An evaluate beat
// first runs the bit-serial divider that forms t, then a read and an
// update state for each term above c[0] through the single multiplier and
// the coefficient store read port, then a final read and combine with c[0].
// A zero-width interval skips all of these. No new beat is taken until the
// result has moved into the output register.
// The result sits in an output register; if m_axis stalls, the block still
// takes load beats and runs the next evaluation, then waits until that
// register is free. Reset (synchronous, active low) empties the output,
// returns the controller to idle and sets a=-1.0, b=+1.0, N=1; the
// coefficient store is not cleared and must be loaded before use.
module chebyshev_series_eval #(
    parameter int MAX_TERMS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] coeff_index, [37:6] coeff_value, [69:38] x_value, [71:70] zero
    input  logic [cse_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] req_type
    input  logic                                s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] series_value, [32] outside_interval, [33] zero_width,
    // [34] saturated, [39:35] zero
    output logic [cse_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cse_pkg::PADDR_W-1:0]         paddr,
    input  logic [cse_pkg::DATA_W-1:0]          pwdata,
    output logic [cse_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    logic [cse_pkg::DATA_W-1:0]  r_low;
    logic [cse_pkg::DATA_W-1:0]  r_high;
    logic [cse_pkg::TERM_W-1:0]  r_terms;

    logic                        cfg_wr;
    cse_pkg::t_cmd               cmd;
    cse_pkg::t_status            status;
    logic [cse_pkg::DATA_W-1:0]  series_value;
    logic                        outside_interval;
    logic                        zero_width;
    logic                        saturated;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= 32'hFFFF_0000;
            r_high  <= 32'h0001_0000;
            r_terms <= 7'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                cse_pkg::REG_LOW:   r_low   <= pwdata;
                cse_pkg::REG_HIGH:  r_high  <= pwdata;
                cse_pkg::REG_TERMS: r_terms <= pwdata[cse_pkg::TERM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cse_pkg::REG_LOW:   prdata = r_low;
            cse_pkg::REG_HIGH:  prdata = r_high;
            cse_pkg::REG_TERMS: prdata = cse_pkg::DATA_W'(r_terms);
            default:            prdata = '0;
        endcase
    end

    cse_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_req_type (s_axis_tuser),
        .o_in_ready    (s_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    cse_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_coeff_index  (s_axis_tdata[5:0]),
        .i_coeff_value  (s_axis_tdata[37:6]),
        .i_x_value      (s_axis_tdata[69:38]),
        .i_low          (r_low),
        .i_high         (r_high),
        .i_term_count   (r_terms),
        .o_series_value (series_value),
        .o_outside      (outside_interval),
        .o_zero_width   (zero_width),
        .o_saturated    (saturated)
    );

    assign m_axis_tdata = {5'b0, saturated, zero_width, outside_interval, series_value};

endmodule
